// ----- rtl/slp_pkg.sv -----
// slp_pkg: types and fixed constants for the shortest lane packer
// no dependencies; imported by the interfaces and the top level
package slp_pkg;

	// field widths of the item channels
	localparam int IMG_W    = 16;
	localparam int LANE_W   = 4;
	localparam int END_W    = 40;
	localparam int CY_W     = 16;
	localparam int HALF_W_W = 31;
	localparam int HH_W     = 16;

	// divisor width of the shared divider (image height is the widest)
	localparam int DIV_VW = 16;

	// register port
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_LANES  = 2'd0;
	localparam logic [LANE_W-1:0] LANES_RESET = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASPECT,
		ST_LENGTH,
		ST_SEARCH,
		ST_CY,
		ST_HH,
		ST_OUT
	} slp_state_t;

endpackage

// ----- rtl/slp_if.sv -----
// slp_in_if / slp_out_if: valid-ready channels for image items and placements
// depends on slp_pkg for field widths
interface slp_in_if import slp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_layout;
	logic [IMG_W-1:0]  image_width;
	logic [IMG_W-1:0]  image_height;

	modport source(output valid, start_layout, image_width, image_height, input ready);
	modport sink(input valid, start_layout, image_width, image_height, output ready);
endinterface

interface slp_out_if import slp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LANE_W-1:0]   chosen_lane;
	logic [END_W-1:0]    centre_x;
	logic [CY_W-1:0]     centre_y;
	logic [HALF_W_W-1:0] half_width;
	logic [HH_W-1:0]     half_height;

	modport source(output valid, chosen_lane, centre_x, centre_y, half_width, half_height,
		input ready);
	modport sink(input valid, chosen_lane, centre_x, centre_y, half_width, half_height,
		output ready);
endinterface

// ----- rtl/shortest_lane_packer.sv -----
// shortest_lane_packer: places each image in the lane with the smallest end
// depends on slp_pkg, slp_if (slp_in_if, slp_out_if) and slp_div
//
//   channel  dir  handshake           carries
//   img      in   valid/ready         start_layout, image_width, image_height
//   place    out  valid/ready         chosen_lane, centre_x, centre_y, half_width,
//                                     half_height
//   apb      in   psel/penable/pready lanes_in_use at byte address 0
//
// one image takes four passes through the single bit-serial divider plus a
// one-lane-per-cycle minimum search; img.ready is high only while the sequencer
// is idle; the result sits in an output register, so a stalled place side holds
// only the next image's final step; reset clears all lane ends and sets lanes to 5
module shortest_lane_packer import slp_pkg::*; #(
	parameter int MAX_LANES = 9,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	slp_in_if.sink            img,
	slp_out_if.source         place
);

	localparam int DW     = IMG_W + FRAC_BITS;
	localparam int LIDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

	slp_state_t state_q, state_d;

	logic [LANE_W-1:0] lanes_q;
	logic [LANE_W-1:0] n_act;
	logic [LANE_W-1:0] n_q;
	logic [END_W-1:0]  lane_end_q [MAX_LANES];

	logic [LANE_W-1:0] idx_q;
	logic [LANE_W-1:0] best_q;
	logic [END_W-1:0]  best_end_q;
	logic [DW-1:0]     length_q;
	logic [CY_W-1:0]   cy_q;
	logic [HH_W-1:0]   hh_q;
	logic              out_valid_q;

	logic [LANE_W-1:0]   out_lane_q;
	logic [END_W-1:0]    out_cx_q;
	logic [CY_W-1:0]     out_cy_q;
	logic [HALF_W_W-1:0] out_hw_q;
	logic [HH_W-1:0]     out_hh_q;

	logic              img_acc;
	logic              out_free;
	logic              search_end;
	logic [END_W-1:0]  cand_end;
	logic [IMG_W-1:0]  h_fix;

	logic              div_start;
	logic              div_done;
	logic [DW-1:0]     div_dividend;
	logic [DIV_VW-1:0] div_divisor;
	logic [DW-1:0]     div_quot;

	logic [END_W-1:0]  length_ext;
	logic [END_W-1:0]  half_ext;
	logic [END_W:0]    cx_sum;
	logic [END_W:0]    nx_sum;
	logic [END_W-1:0]  cx_sat;
	logic [END_W-1:0]  nx_sat;

	logic cfg_wr;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LANES);
	assign prdata = (paddr == ADDR_LANES) ? APB_DW'(lanes_q) : '0;

	// lane count zero means one lane, above the storage means all of it
	always_comb begin
		if (lanes_q == '0)
			n_act = LANE_W'(1);
		else if ({1'b0, lanes_q} > 5'(MAX_LANES))
			n_act = LANE_W'(MAX_LANES);
		else
			n_act = lanes_q;
	end

	assign h_fix      = (img.image_height == '0) ? IMG_W'(1) : img.image_height;
	assign img_acc    = img.valid && img.ready;
	assign out_free   = !out_valid_q || place.ready;
	assign search_end = idx_q >= n_q;
	assign cand_end   = lane_end_q[idx_q[LIDX_W-1:0]];

	assign length_ext = END_W'(length_q);
	assign half_ext   = length_ext >> 1;
	assign cx_sum     = {1'b0, best_end_q} + {1'b0, half_ext};
	assign nx_sum     = {1'b0, best_end_q} + {1'b0, length_ext};
	assign cx_sat     = cx_sum[END_W] ? '1 : cx_sum[END_W-1:0];
	assign nx_sat     = nx_sum[END_W] ? '1 : nx_sum[END_W-1:0];

	slp_div #(
		.DW (DW),
		.VW (DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (img_acc) state_d = ST_ASPECT;
			ST_ASPECT: if (div_done) state_d = ST_LENGTH;
			ST_LENGTH: if (div_done) state_d = ST_SEARCH;
			ST_SEARCH: if (search_end) state_d = ST_CY;
			ST_CY:     if (div_done) state_d = ST_HH;
			ST_HH:     if (div_done) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: divider launch and operand select
	always_comb begin
		img.ready    = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				img.ready    = 1'b1;
				div_start    = img.valid;
				div_dividend = DW'(img.image_width) << FRAC_BITS;
				div_divisor  = h_fix;
			end
			ST_ASPECT: begin
				div_start    = div_done;
				div_dividend = div_quot;
				div_divisor  = DIV_VW'(n_q);
			end
			ST_SEARCH: begin
				div_start    = search_end;
				div_dividend = DW'({best_q, 1'b1}) << FRAC_BITS;
				div_divisor  = DIV_VW'({n_q, 1'b0});
			end
			ST_CY: begin
				div_start    = div_done;
				div_dividend = DW'(1) << FRAC_BITS;
				div_divisor  = DIV_VW'({n_q, 1'b0});
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lanes_q     <= LANES_RESET;
			n_q         <= LANE_W'(1);
			idx_q       <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LANES; i++)
				lane_end_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr)
				lanes_q <= pwdata[LANE_W-1:0];
			if (img_acc) begin
				n_q <= n_act;
				if (img.start_layout) begin
					for (int i = 0; i < MAX_LANES; i++)
						lane_end_q[i] <= '0;
				end
			end
			if (state_q == ST_LENGTH && div_done) begin
				idx_q  <= LANE_W'(1);
				best_q <= '0;
			end
			if (state_q == ST_SEARCH && !search_end) begin
				if (cand_end < best_end_q)
					best_q <= idx_q;
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				lane_end_q[best_q[LIDX_W-1:0]] <= nx_sat;
				out_valid_q <= 1'b1;
			end else if (place.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LENGTH && div_done) begin
			length_q   <= div_quot;
			best_end_q <= lane_end_q[0];
		end
		// strict compare keeps the lowest index on ties
		if (state_q == ST_SEARCH && !search_end && cand_end < best_end_q)
			best_end_q <= cand_end;
		if (state_q == ST_CY && div_done)
			cy_q <= div_quot[CY_W-1:0];
		if (state_q == ST_HH && div_done)
			hh_q <= div_quot[HH_W-1:0];
		if (state_q == ST_OUT && out_free) begin
			out_lane_q <= best_q;
			out_cx_q   <= cx_sat;
			out_cy_q   <= cy_q;
			out_hw_q   <= half_ext[HALF_W_W-1:0];
			out_hh_q   <= hh_q;
		end
	end

	assign place.valid       = out_valid_q;
	assign place.chosen_lane = out_lane_q;
	assign place.centre_x    = out_cx_q;
	assign place.centre_y    = out_cy_q;
	assign place.half_width  = out_hw_q;
	assign place.half_height = out_hh_q;

endmodule

// ----- rtl/slp_div.sv -----
// slp_div: restoring unsigned divider, one quotient bit per cycle
// standalone; shared by all divisions of the shortest lane packer
module slp_div #(
	parameter int DW = 32,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;

	logic [VW:0]   partial;
	logic [VW:0]   diff;
	logic          ge;
	logic [VW-1:0] rem_nx;

	assign partial  = {rem_q, q_q[DW-1]};
	assign ge       = partial >= {1'b0, d_q};
	assign diff     = partial - {1'b0, d_q};
	assign rem_nx   = ge ? diff[VW-1:0] : partial[VW-1:0];
	assign done     = run_q && (cnt_q == '0);
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(DW);
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			q_q   <= {q_q[DW-2:0], ge};
			rem_q <= rem_nx;
		end
	end

endmodule
